/* sv/toalu_pkg.sv */
// shared types, operation codes and constant table for the two-operand alu
`default_nettype none

package toalu_pkg;

	localparam int unsigned REG_COUNT = 8;
	localparam int unsigned REG_AW    = 3;
	localparam int unsigned DATA_W    = 16;

	localparam logic [DATA_W-1:0] BYTE_MASK = 16'h00FF;
	localparam logic [DATA_W-1:0] WORD_MASK = 16'hFFFF;
	localparam logic [DATA_W-1:0] BYTE_SIGN = 16'h0080;
	localparam logic [DATA_W-1:0] WORD_SIGN = 16'h8000;

	typedef enum logic [4:0] {
		OP_ADD  = 5'd0,
		OP_ADDC = 5'd1,
		OP_SUB  = 5'd2,
		OP_SUBC = 5'd3,
		OP_CMP  = 5'd4,
		OP_XOR  = 5'd5,
		OP_AND  = 5'd6,
		OP_BIT  = 5'd7,
		OP_BIC  = 5'd8,
		OP_BIS  = 5'd9,
		OP_MOV  = 5'd10,
		OP_SWAP = 5'd11,
		OP_SRA  = 5'd12,
		OP_RRC  = 5'd13,
		OP_SWPB = 5'd14,
		OP_SXT  = 5'd15,
		OP_NOP  = 5'd16
	} op_t;

	typedef struct packed {
		logic n;
		logic z;
		logic c;
		logic v;
	} flags_t;

	typedef struct packed {
		logic [DATA_W-1:0] result;
		logic [DATA_W-1:0] swap_val;
		flags_t            flags;
		logic              dst_we;
		logic              src_we;
	} exec_res_t;

	function automatic logic [DATA_W-1:0] const_value(input logic [REG_AW-1:0] idx);
		logic [DATA_W-1:0] v;
		case (idx)
			3'd0: v = 16'd0;
			3'd1: v = 16'd1;
			3'd2: v = 16'd2;
			3'd3: v = 16'd4;
			3'd4: v = 16'd8;
			3'd5: v = 16'd32;
			3'd6: v = 16'd48;
			3'd7: v = 16'hFFFF;
			default: v = 16'd0;
		endcase
		return v;
	endfunction

endpackage

`default_nettype wire

/* sv/toalu_regfile.sv */
// eight-entry register file: two registered read ports, one write port, write-first
`default_nettype none

module toalu_regfile
	import toalu_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              rd_en,
	input  wire logic [REG_AW-1:0] rd_addr_a,
	input  wire logic [REG_AW-1:0] rd_addr_b,
	output logic      [DATA_W-1:0] rd_data_a,
	output logic      [DATA_W-1:0] rd_data_b,
	input  wire logic              wr_en,
	input  wire logic [REG_AW-1:0] wr_addr,
	input  wire logic [DATA_W-1:0] wr_data
);

	logic [DATA_W-1:0]    mem_q [REG_COUNT];
	logic [REG_COUNT-1:0] vld_q;
	logic [DATA_W-1:0]    rdat_a_q;
	logic [DATA_W-1:0]    rdat_b_q;
	logic [DATA_W-1:0]    wdat_q;
	logic                 fwd_a_q;
	logic                 fwd_b_q;
	logic                 vld_a_q;
	logic                 vld_b_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rdat_a_q <= mem_q[rd_addr_a];
			rdat_b_q <= mem_q[rd_addr_b];
			wdat_q   <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q   <= '0;
			fwd_a_q <= 1'b0;
			fwd_b_q <= 1'b0;
			vld_a_q <= 1'b0;
			vld_b_q <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				fwd_a_q <= wr_en && (wr_addr == rd_addr_a);
				fwd_b_q <= wr_en && (wr_addr == rd_addr_b);
				vld_a_q <= vld_q[rd_addr_a];
				vld_b_q <= vld_q[rd_addr_b];
			end
		end
	end

	// entries never written read as zero
	assign rd_data_a = fwd_a_q ? wdat_q : (vld_a_q ? rdat_a_q : '0);
	assign rd_data_b = fwd_b_q ? wdat_q : (vld_b_q ? rdat_b_q : '0);

endmodule

`default_nettype wire

/* sv/toalu_exec.sv */
// execute logic: operand selection, adder, logic and shift ops, flag update
`default_nettype none

module toalu_exec
	import toalu_pkg::*;
(
	input  wire logic [4:0]        kind,
	input  wire logic              use_constant,
	input  wire logic              byte_mode,
	input  wire logic [REG_AW-1:0] source_index,
	input  wire logic [REG_AW-1:0] dest_index,
	input  wire logic [DATA_W-1:0] src_reg,
	input  wire logic [DATA_W-1:0] dst_reg,
	input  wire flags_t            flags_in,
	output exec_res_t              res
);

	always_comb begin
		op_t               op;
		logic [DATA_W-1:0] msk;
		logic [DATA_W-1:0] wmsk;
		logic [DATA_W-1:0] sb;
		logic [DATA_W-1:0] s;
		logic [DATA_W-1:0] d;
		logic [DATA_W-1:0] bop;
		logic [DATA_W-1:0] arith_r;
		logic [DATA_W-1:0] r;
		logic [DATA_W-1:0] nv;
		logic [DATA_W-1:0] sv;
		logic [DATA_W:0]   sum;
		logic              add_cin;
		logic              arith_c;
		logic              arith_v;
		logic              write;
		logic              set_nz;
		logic              logic_c;
		logic              zr;
		logic              ng;
		flags_t            f;

		op  = op_t'(kind);
		msk = byte_mode ? BYTE_MASK : WORD_MASK;
		sb  = byte_mode ? BYTE_SIGN : WORD_SIGN;
		s   = (use_constant ? const_value(source_index) : src_reg) & msk;
		d   = dst_reg & msk;

		bop     = s;
		add_cin = 1'b0;
		case (op) inside
			OP_ADDC: begin
				add_cin = flags_in.c;
			end
			OP_SUB, OP_CMP: begin
				bop     = ~s & msk;
				add_cin = 1'b1;
			end
			OP_SUBC: begin
				bop     = ~s & msk;
				add_cin = flags_in.c;
			end
			default: begin
				bop     = s;
				add_cin = 1'b0;
			end
		endcase

		sum     = {1'b0, d} + {1'b0, bop} + {{DATA_W{1'b0}}, add_cin};
		arith_r = sum[DATA_W-1:0] & msk;
		arith_c = byte_mode ? sum[8] : sum[DATA_W];
		arith_v = ((~(d ^ bop) & (d ^ arith_r) & sb) != '0);

		f       = flags_in;
		r       = '0;
		wmsk    = msk;
		write   = 1'b0;
		set_nz  = 1'b0;
		logic_c = 1'b0;

		case (op) inside
			OP_ADD, OP_ADDC, OP_SUB, OP_SUBC: begin
				r      = arith_r;
				write  = 1'b1;
				set_nz = 1'b1;
				f.c    = arith_c;
				f.v    = arith_v;
			end
			OP_CMP: begin
				r      = arith_r;
				set_nz = 1'b1;
				f.c    = arith_c;
				f.v    = arith_v;
			end
			OP_XOR: begin
				r       = d ^ s;
				write   = 1'b1;
				set_nz  = 1'b1;
				logic_c = 1'b1;
			end
			OP_AND: begin
				r       = d & s;
				write   = 1'b1;
				set_nz  = 1'b1;
				logic_c = 1'b1;
			end
			OP_BIT: begin
				r       = d & s;
				set_nz  = 1'b1;
				logic_c = 1'b1;
			end
			OP_BIC: begin
				r     = d & ~s & msk;
				write = 1'b1;
			end
			OP_BIS: begin
				r     = d | s;
				write = 1'b1;
			end
			OP_MOV, OP_SWAP: begin
				r     = s;
				write = 1'b1;
			end
			OP_SRA: begin
				r      = (d >> 1) | (d & sb);
				write  = 1'b1;
				set_nz = 1'b1;
				f.c    = d[0];
				f.v    = 1'b0;
			end
			OP_RRC: begin
				r      = (d >> 1) | (flags_in.c ? sb : '0);
				write  = 1'b1;
				set_nz = 1'b1;
				f.c    = d[0];
				f.v    = 1'b0;
			end
			OP_SWPB: begin
				wmsk  = WORD_MASK;
				r     = {dst_reg[7:0], dst_reg[15:8]};
				write = 1'b1;
			end
			OP_SXT: begin
				wmsk    = WORD_MASK;
				r       = {{8{dst_reg[7]}}, dst_reg[7:0]};
				write   = 1'b1;
				set_nz  = 1'b1;
				logic_c = 1'b1;
			end
			default: begin
				r     = '0;
				write = 1'b0;
			end
		endcase

		zr = ((r & wmsk) == '0);
		ng = (wmsk == WORD_MASK) ? r[15] : r[7];
		if (set_nz) begin
			f.z = zr;
			f.n = ng;
		end
		if (logic_c) begin
			f.c = !zr;
			f.v = 1'b0;
		end

		nv = (dst_reg & ~wmsk) | (r & wmsk);
		sv = (src_reg & ~msk) | d;

		res.result   = write ? nv : r;
		res.swap_val = ((op == OP_SWAP) && !use_constant) ? sv : '0;
		res.flags    = f;
		res.dst_we   = write;
		res.src_we   = (op == OP_SWAP) && !use_constant && (source_index != dest_index);
	end

endmodule

`default_nettype wire

/* sv/two_operand_alu_with_register_file.sv */
// top level: two-operand alu with eight-entry register file and status flags
//
//  channel | handshake             | payload
//  --------+-----------------------+--------------------------------------------------
//  in      | in_valid / in_ready   | kind, use_constant, byte_mode, source_index,
//          |                       | dest_index
//  out     | out_valid / out_ready | result_value, swap_value, flag_negative,
//          |                       | flag_zero, flag_carry, flag_overflow
//
// an instruction reads the register file when accepted and executes in the next cycle,
// writing back and loading the output register once that register is free or being taken
// one instruction per cycle while the output is taken; swap with a register source
// blocks input as it commits, since its second write uses the single write port next cycle
// reset clears the register file valid bits, the flags and all valid flags
// a full output register that is not taken holds the execute stage, which holds the input
`default_nettype none

module two_operand_alu_with_register_file
	import toalu_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [4:0]  kind,
	input  wire logic        use_constant,
	input  wire logic        byte_mode,
	input  wire logic [2:0]  source_index,
	input  wire logic [2:0]  dest_index,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [15:0]      result_value,
	output logic [15:0]      swap_value,
	output logic             flag_negative,
	output logic             flag_zero,
	output logic             flag_carry,
	output logic             flag_overflow
);

	logic              s1_valid_q;
	logic [4:0]        kind_s1;
	logic              uc_s1;
	logic              bm_s1;
	logic [REG_AW-1:0] si_s1;
	logic [REG_AW-1:0] di_s1;

	flags_t            flags_q;
	logic              pend_q;
	logic [REG_AW-1:0] pend_addr_q;
	logic [DATA_W-1:0] pend_data_q;

	logic              out_valid_q;
	logic [DATA_W-1:0] result_q;
	logic [DATA_W-1:0] swap_q;
	flags_t            out_flags_q;

	logic [DATA_W-1:0] src_reg;
	logic [DATA_W-1:0] dst_reg;
	exec_res_t         res;
	logic              commit;
	logic              accept;
	logic              wr_en;
	logic [REG_AW-1:0] wr_addr;
	logic [DATA_W-1:0] wr_data;

	assign commit   = s1_valid_q && (!out_valid_q || out_ready);
	assign in_ready = !s1_valid_q || (commit && !res.src_we);
	assign accept   = in_valid && in_ready;

	// second swap write never meets a commit
	assign wr_en   = (commit && res.dst_we) || pend_q;
	assign wr_addr = pend_q ? pend_addr_q : di_s1;
	assign wr_data = pend_q ? pend_data_q : res.result;

	toalu_regfile u_regfile (
		.clk       (clk),
		.arst_n    (arst_n),
		.rd_en     (accept),
		.rd_addr_a (source_index),
		.rd_addr_b (dest_index),
		.rd_data_a (src_reg),
		.rd_data_b (dst_reg),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data)
	);

	toalu_exec u_exec (
		.kind         (kind_s1),
		.use_constant (uc_s1),
		.byte_mode    (bm_s1),
		.source_index (si_s1),
		.dest_index   (di_s1),
		.src_reg      (src_reg),
		.dst_reg      (dst_reg),
		.flags_in     (flags_q),
		.res          (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			pend_q      <= 1'b0;
			flags_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				s1_valid_q <= 1'b1;
			end else if (commit) begin
				s1_valid_q <= 1'b0;
			end
			pend_q <= commit && res.src_we;
			if (commit) begin
				flags_q <= res.flags;
			end
			if (commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_s1 <= kind;
			uc_s1   <= use_constant;
			bm_s1   <= byte_mode;
			si_s1   <= source_index;
			di_s1   <= dest_index;
		end
		if (commit) begin
			pend_addr_q <= si_s1;
			pend_data_q <= res.swap_val;
			result_q    <= res.result;
			swap_q      <= res.swap_val;
			out_flags_q <= res.flags;
		end
	end

	assign out_valid     = out_valid_q;
	assign result_value  = result_q;
	assign swap_value    = swap_q;
	assign flag_negative = out_flags_q.n;
	assign flag_zero     = out_flags_q.z;
	assign flag_carry    = out_flags_q.c;
	assign flag_overflow = out_flags_q.v;

	// second swap write happens with the execute stage empty
	a_pend_alone: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q |-> !s1_valid_q)
		else $error("second swap write overlaps an executing transaction");

	a_swap_pend: assert property (@(posedge clk) disable iff (!arst_n)
		(commit && res.src_we) |=> pend_q)
		else $error("swap source write not scheduled");

	a_commit_out: assert property (@(posedge clk) disable iff (!arst_n)
		commit |=> out_valid_q)
		else $error("executed transaction did not reach the output register");

	a_flags_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!commit |=> $stable(flags_q))
		else $error("flags changed without an executed transaction");

endmodule

`default_nettype wire
